FILE: rtl/http_response_body_deframer_unit_defines.svh
// Assertion macros for the HTTP response body deframer.
`ifndef HTTP_RESPONSE_BODY_DEFRAMER_UNIT_DEFINES_SVH
`define HTTP_RESPONSE_BODY_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define HRBD_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("hrbd: assertion failed");
`define HRBD_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("hrbd: assertion failed");
`else
`define HRBD_ASSERT_NOW(lbl, cond, prop)
`define HRBD_ASSERT_NEXT(lbl, cond, prop)
`endif

`endif

FILE: rtl/hrbd_pkg.sv
// Types and constants shared by the HTTP response body deframer.
package hrbd_pkg;

  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_CLOSE = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  localparam logic [4:0] CL_LEN     = 5'd15;
  localparam logic [4:0] TE_LEN     = 5'd26;
  localparam logic [4:0] DIGIT_SEEN = 5'd16;

  localparam logic [7:0] CL_TEXT [15] = '{
    "C", "o", "n", "t", "e", "n", "t", "-", "L", "e", "n", "g", "t", "h", ":"
  };
  localparam logic [7:0] TE_TEXT [26] = '{
    "T", "r", "a", "n", "s", "f", "e", "r", "-", "E", "n", "c", "o", "d",
    "i", "n", "g", ":", " ", "c", "h", "u", "n", "k", "e", "d"
  };

  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_PLAIN  = 7'b0000010,
    PH_CSIZE  = 7'b0000100,
    PH_CEXT   = 7'b0001000,
    PH_CDATA  = 7'b0010000,
    PH_CTRAIL = 7'b0100000,
    PH_DONE   = 7'b1000000
  } hrbd_phase_e;

  typedef struct packed {
    hrbd_phase_e phase;
    logic [4:0]  match_pos;
    logic [1:0]  candidates;
    logic        after_newline;
    logic        parsing_digits;
    logic        length_given;
    logic        chunked_mode;
  } hrbd_ctl_t;

  localparam hrbd_ctl_t CTL_RESET = '{
    phase:          PH_HEADER,
    match_pos:      5'd0,
    candidates:     2'b11,
    after_newline:  1'b0,
    parsing_digits: 1'b0,
    length_given:   1'b0,
    chunked_mode:   1'b0
  };

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } hrbd_item_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       byte_valid;
    logic       end_of_body;
  } hrbd_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (is_digit(c)) begin
      v = c - 8'h30;
    end else if ((c >= "a") && (c <= "f")) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

FILE: rtl/hrbd_if.sv
// Request and result channel interfaces of the HTTP response body deframer.
interface hrbd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface hrbd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       byte_valid;
  logic       end_of_body;

  modport source (output valid, output body_byte, output byte_valid, output end_of_body,
                  input ready);
  modport sink (input valid, input body_byte, input byte_valid, input end_of_body,
                output ready);
endinterface

FILE: rtl/hrbd_in_reg.sv
// Input register stage: holds one request until the parser takes it.
module hrbd_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  hrbd_req_if.sink            req_i,
  input  logic                take_i,
  output logic                valid_o,
  output hrbd_pkg::hrbd_item_t item_o
);
  import hrbd_pkg::*;

  logic       valid_q;
  hrbd_item_t item_q;

  assign req_i.ready = !valid_q || take_i;
  assign valid_o     = valid_q;
  assign item_o      = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      item_q <= '{action: req_i.action, rx_byte: req_i.rx_byte};
    end
  end

endmodule

FILE: rtl/hrbd_step.sv
// Parser step: next state and optional result for one request.
module hrbd_step #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  hrbd_pkg::hrbd_item_t   item_i,
  input  hrbd_pkg::hrbd_ctl_t    ctl_i,
  input  logic [LENGTH_BITS-1:0] declared_i,
  input  logic [LENGTH_BITS-1:0] counted_i,
  input  logic [LENGTH_BITS-1:0] chunk_i,
  output hrbd_pkg::hrbd_ctl_t    ctl_o,
  output logic [LENGTH_BITS-1:0] declared_o,
  output logic [LENGTH_BITS-1:0] counted_o,
  output logic [LENGTH_BITS-1:0] chunk_o,
  output logic                   has_result_o,
  output hrbd_pkg::hrbd_result_t result_o
);
  import hrbd_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  logic [7:0]             c;
  logic [LENGTH_BITS+3:0] dec_sum;
  logic [LENGTH_BITS-1:0] dec_next;
  logic [LENGTH_BITS-1:0] hex_next;
  logic [LENGTH_BITS-1:0] plain_cnt;
  logic [LENGTH_BITS-1:0] data_cnt;
  logic [1:0]             cand_m;
  logic [4:0]             pos_inc;

  assign c = item_i.rx_byte;

  // declared * 10 + digit, saturating
  assign dec_sum = {1'b0, declared_i, 3'b000} + {3'b000, declared_i, 1'b0}
                 + {{LENGTH_BITS{1'b0}}, c[3:0]};
  assign dec_next = (dec_sum[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? LEN_MAX
                                                                  : dec_sum[LENGTH_BITS-1:0];
  assign hex_next = (chunk_i[LENGTH_BITS-1 -: 4] != 4'd0) ? LEN_MAX
                  : {chunk_i[LENGTH_BITS-5:0], hex_value(c)};
  assign plain_cnt = (counted_i != LEN_MAX) ? counted_i + 1'b1 : counted_i;
  assign data_cnt  = counted_i + 1'b1;

  assign cand_m[0] = ctl_i.candidates[0] && (ctl_i.match_pos < CL_LEN)
                   && (CL_TEXT[ctl_i.match_pos[3:0]] == c);
  assign cand_m[1] = ctl_i.candidates[1] && (ctl_i.match_pos < TE_LEN)
                   && (TE_TEXT[ctl_i.match_pos] == c);
  assign pos_inc   = ctl_i.match_pos + 5'd1;

  always_comb begin
    ctl_o        = ctl_i;
    declared_o   = declared_i;
    counted_o    = counted_i;
    chunk_o      = chunk_i;
    has_result_o = 1'b0;
    result_o     = '0;
    unique case (item_i.action)
      ACT_START: begin
        ctl_o      = CTL_RESET;
        declared_o = '0;
        counted_o  = '0;
        chunk_o    = '0;
      end
      ACT_CLOSE: begin
        if (ctl_i.phase != PH_DONE) begin
          ctl_o.phase          = PH_DONE;
          has_result_o         = 1'b1;
          result_o.end_of_body = 1'b1;
        end
      end
      ACT_BYTE: begin
        unique case (ctl_i.phase) inside
          PH_HEADER: begin
            if (c == CHAR_CR) begin
              ctl_o = ctl_i;
            end else if (c == CHAR_LF) begin
              if (ctl_i.after_newline) begin
                if (ctl_i.chunked_mode) begin
                  ctl_o.phase = PH_CSIZE;
                  chunk_o     = '0;
                end else begin
                  counted_o = '0;
                  if (ctl_i.length_given && (declared_i == '0)) begin
                    ctl_o.phase          = PH_DONE;
                    has_result_o         = 1'b1;
                    result_o.end_of_body = 1'b1;
                  end else begin
                    ctl_o.phase = PH_PLAIN;
                  end
                end
              end else begin
                ctl_o.after_newline  = 1'b1;
                ctl_o.match_pos      = 5'd0;
                ctl_o.candidates     = 2'b11;
                ctl_o.parsing_digits = 1'b0;
              end
            end else begin
              ctl_o.after_newline = 1'b0;
              if (ctl_i.parsing_digits) begin
                if (is_digit(c)) begin
                  declared_o      = dec_next;
                  ctl_o.match_pos = DIGIT_SEEN;
                end else if (!(((c == CHAR_SP) || (c == CHAR_TAB))
                               && (ctl_i.match_pos == CL_LEN))) begin
                  ctl_o.parsing_digits = 1'b0;
                end
              end else if ((ctl_i.candidates != 2'b00) && (ctl_i.match_pos < TE_LEN)) begin
                ctl_o.candidates = cand_m;
                if (cand_m != 2'b00) begin
                  ctl_o.match_pos = pos_inc;
                  if (cand_m[0] && (pos_inc == CL_LEN)) begin
                    ctl_o.length_given   = 1'b1;
                    ctl_o.parsing_digits = 1'b1;
                    ctl_o.candidates     = 2'b00;
                    declared_o           = '0;
                  end else if (cand_m[1] && (pos_inc == TE_LEN)) begin
                    ctl_o.chunked_mode = 1'b1;
                    ctl_o.candidates   = 2'b00;
                  end
                end
              end
            end
          end
          PH_PLAIN: begin
            counted_o           = plain_cnt;
            has_result_o        = 1'b1;
            result_o.body_byte  = c;
            result_o.byte_valid = 1'b1;
            if (ctl_i.length_given && (plain_cnt >= declared_i)) begin
              ctl_o.phase          = PH_DONE;
              result_o.end_of_body = 1'b1;
            end
          end
          PH_CSIZE, PH_CEXT: begin
            if (c == CHAR_LF) begin
              if (chunk_i == '0) begin
                ctl_o.phase          = PH_DONE;
                has_result_o         = 1'b1;
                result_o.end_of_body = 1'b1;
              end else begin
                counted_o   = '0;
                ctl_o.phase = PH_CDATA;
              end
            end else if ((c != CHAR_CR) && (ctl_i.phase == PH_CSIZE)) begin
              if (is_hex(c)) begin
                chunk_o = hex_next;
              end else begin
                ctl_o.phase = PH_CEXT;
              end
            end
          end
          PH_CDATA: begin
            counted_o           = data_cnt;
            has_result_o        = 1'b1;
            result_o.body_byte  = c;
            result_o.byte_valid = 1'b1;
            if (data_cnt >= chunk_i) begin
              ctl_o.phase = PH_CTRAIL;
            end
          end
          PH_CTRAIL: begin
            if (c == CHAR_LF) begin
              chunk_o     = '0;
              ctl_o.phase = PH_CSIZE;
            end
          end
          default: begin
            ctl_o = ctl_i;
          end
        endcase
      end
      default: begin
        ctl_o = ctl_i;
      end
    endcase
  end

endmodule

FILE: rtl/http_response_body_deframer_unit.sv
// Top level of the HTTP response body deframer: state, result register, checks.
// Takes one request per clock (a response byte, a connection close or a new
// response start), except while the input stalls, and passes on the body bytes
// of an HTTP/1.1 response, plain (Content-Length or read to close) or chunked.
// Every request is parsed combinationally while it sits in the input register;
// when it is taken, the parser state is updated and any result it yields is written
// to the result register, whose output is the response channel. A result
// register holds a finished result; while it waits unaccepted the input register
// keeps its request and the input stalls. A request that yields no result simply
// updates the parser state. Lengths are LENGTH_BITS wide and saturate at their
// maximum.
`include "http_response_body_deframer_unit_defines.svh"

module http_response_body_deframer_unit #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hrbd_req_if.sink   req_i,
  hrbd_rsp_if.source rsp_o
);
  import hrbd_pkg::*;

  logic                   in_valid;
  hrbd_item_t             item;
  logic                   fire;
  hrbd_ctl_t              ctl_q, ctl_d;
  logic [LENGTH_BITS-1:0] declared_q, declared_d;
  logic [LENGTH_BITS-1:0] counted_q, counted_d;
  logic [LENGTH_BITS-1:0] chunk_q, chunk_d;
  logic                   has_result;
  hrbd_result_t           result;
  logic                   rsp_valid_q;
  hrbd_result_t           rsp_q;

  assign fire = in_valid && (!rsp_valid_q || rsp_o.ready);

  hrbd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .take_i  (fire),
    .valid_o (in_valid),
    .item_o  (item)
  );

  hrbd_step #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .item_i       (item),
    .ctl_i        (ctl_q),
    .declared_i   (declared_q),
    .counted_i    (counted_q),
    .chunk_i      (chunk_q),
    .ctl_o        (ctl_d),
    .declared_o   (declared_d),
    .counted_o    (counted_d),
    .chunk_o      (chunk_d),
    .has_result_o (has_result),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= CTL_RESET;
      declared_q  <= '0;
      counted_q   <= '0;
      chunk_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        ctl_q      <= ctl_d;
        declared_q <= declared_d;
        counted_q  <= counted_d;
        chunk_q    <= chunk_d;
      end
      if (fire && has_result) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_result) begin
      rsp_q <= result;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.body_byte   = rsp_q.body_byte;
  assign rsp_o.byte_valid  = rsp_q.byte_valid;
  assign rsp_o.end_of_body = rsp_q.end_of_body;

  `HRBD_ASSERT_NEXT(a_end_sets_done, fire && has_result && result.end_of_body, ctl_q.phase == PH_DONE)
  `HRBD_ASSERT_NOW(a_done_is_quiet, fire && (ctl_q.phase == PH_DONE), !has_result)
  `HRBD_ASSERT_NOW(a_bare_result_ends, rsp_valid_q && !rsp_q.byte_valid, rsp_q.end_of_body)

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the HTTP response body deframer: random responses, scoreboard.
module tb;
  import hrbd_pkg::*;

  localparam int          LEN_BITS   = 32;
  localparam logic [63:0] LEN_MAX    = (64'd1 << LEN_BITS) - 64'd1;
  localparam logic [1:0]  ACT_UNUSED = 2'd3;
  localparam int          QUIET_MAX  = 2000;
  localparam int          ITEM_GOAL  = 600;
  localparam int          DRAIN_WAIT = 8;

  class body_scoreboard;
    hrbd_phase_e  phase;
    logic [4:0]   match_pos;
    logic [1:0]   cands;
    bit           after_nl;
    bit           in_digits;
    bit           len_given;
    bit           chunked;
    bit           done;
    logic [63:0]  decl_len;
    logic [63:0]  count;
    logic [63:0]  csize;
    hrbd_result_t pending_body_q[$];
    int           errors;
    int           checked;

    function new();
      clear();
      errors  = 0;
      checked = 0;
    endfunction

    function void clear();
      phase     = PH_HEADER;
      match_pos = '0;
      cands     = 2'b11;
      after_nl  = 1'b0;
      in_digits = 1'b0;
      len_given = 1'b0;
      chunked   = 1'b0;
      done      = 1'b0;
      decl_len  = '0;
      count     = '0;
      csize     = '0;
    endfunction

    function void emit(logic [7:0] b, logic v, logic e);
      hrbd_result_t r;
      r.body_byte   = v ? b : 8'h00;
      r.byte_valid  = v;
      r.end_of_body = e;
      if (e) done = 1'b1;
      pending_body_q.push_back(r);
    endfunction

    function void finish_body();
      phase = PH_DONE;
      emit(8'h00, 1'b0, 1'b1);
    endfunction

    function int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    function void end_header();
      if (chunked) begin
        phase = PH_CSIZE;
        csize = '0;
        return;
      end
      count = '0;
      if (len_given && decl_len == 0) begin
        finish_body();
        return;
      end
      phase = PH_PLAIN;
    endfunction

    function void header_char(logic [7:0] c);
      logic [63:0] d;
      after_nl = 1'b0;
      if (in_digits) begin
        if (c >= "0" && c <= "9") begin
          d = 64'(c - "0");
          if (decl_len > (LEN_MAX - d) / 10) decl_len = LEN_MAX;
          else decl_len = decl_len * 10 + d;
          match_pos = DIGIT_SEEN;
        end else if (!((c == CHAR_SP || c == CHAR_TAB) && match_pos == CL_LEN)) begin
          in_digits = 1'b0;
        end
        return;
      end
      if (cands == 2'b00 || match_pos >= TE_LEN) return;
      if (cands[0] && (match_pos >= CL_LEN || CL_TEXT[match_pos] != c)) cands[0] = 1'b0;
      if (cands[1] && TE_TEXT[match_pos] != c) cands[1] = 1'b0;
      if (cands == 2'b00) return;
      match_pos++;
      if (cands[0] && match_pos == CL_LEN) begin
        len_given = 1'b1;
        decl_len  = '0;
        in_digits = 1'b1;
        cands     = 2'b00;
      end else if (cands[1] && match_pos == TE_LEN) begin
        chunked = 1'b1;
        cands   = 2'b00;
      end
    endfunction

    function void take_byte(logic [7:0] c);
      int h;
      case (phase)
        PH_HEADER: begin
          if (c == CHAR_LF) begin
            if (after_nl) begin
              end_header();
            end else begin
              after_nl  = 1'b1;
              match_pos = '0;
              cands     = 2'b11;
              in_digits = 1'b0;
            end
          end else if (c != CHAR_CR) begin
            header_char(c);
          end
        end
        PH_PLAIN: begin
          if (count < LEN_MAX) count++;
          if (len_given && count >= decl_len) begin
            phase = PH_DONE;
            emit(c, 1'b1, 1'b1);
          end else begin
            emit(c, 1'b1, 1'b0);
          end
        end
        PH_CSIZE, PH_CEXT: begin
          if (c == CHAR_LF) begin
            if (csize == 0) begin
              finish_body();
            end else begin
              count = '0;
              phase = PH_CDATA;
            end
          end else if (c != CHAR_CR && phase == PH_CSIZE) begin
            h = hex_digit(c);
            if (h < 0) phase = PH_CEXT;
            else if (csize > (LEN_MAX >> 4)) csize = LEN_MAX;
            else csize = (csize << 4) | 64'(h);
          end
        end
        PH_CDATA: begin
          count++;
          if (count >= csize) phase = PH_CTRAIL;
          emit(c, 1'b1, 1'b0);
        end
        PH_CTRAIL: begin
          if (c == CHAR_LF) begin
            csize = '0;
            phase = PH_CSIZE;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_request(logic [1:0] act, logic [7:0] c);
      case (act)
        ACT_START: clear();
        ACT_CLOSE: if (!done && phase != PH_DONE) finish_body();
        ACT_BYTE:  take_byte(c);
        default:   ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch %0d: %s", errors, msg);
    endtask

    task check_result(logic [7:0] b, logic v, logic e);
      hrbd_result_t want;
      checked++;
      if (pending_body_q.size() == 0) begin
        report($sformatf("result with none expected: byte %02h valid %0b end %0b", b, v, e));
        return;
      end
      want = pending_body_q.pop_front();
      if (b !== want.body_byte)
        report($sformatf("result %0d body_byte %02h, want %02h", checked, b, want.body_byte));
      if (v !== want.byte_valid)
        report($sformatf("result %0d byte_valid %0b, want %0b", checked, v, want.byte_valid));
      if (e !== want.end_of_body)
        report($sformatf("result %0d end_of_body %0b, want %0b", checked, e, want.end_of_body));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  hrbd_req_if req_if ();
  hrbd_rsp_if rsp_if ();

  http_response_body_deframer_unit #(
    .LENGTH_BITS(LEN_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  body_scoreboard sb;
  bit             steady;
  int             quiet_cycles;
  int             requests_sent;
  int             resp_count;
  int             n_plain, n_chunked, n_close, n_broken, n_overflow, n_noise;

  string filler_lines[11] = '{
    "Server: bench", "Content-Type: text/plain", "content-length: 5", "Content-Lengt: 3",
    "Transfer-Encoding: gzip", "Transfer-Encoding: chunkeD", "X-Content-Length: 9",
    "Content-Length 7", "Transfer-Encoding:chunked", "Transfer-", "Content-Length"
  };

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    rsp_if.ready <= steady || ($urandom_range(99) >= 19);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) sb.note_request(req_if.action, req_if.rx_byte);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result(rsp_if.body_byte, rsp_if.byte_valid, rsp_if.end_of_body);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_MAX) begin
          $display("timeout: no handshake for %0d cycles", QUIET_MAX);
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  task automatic send_req(logic [1:0] act, logic [7:0] c);
    while (!steady && $urandom_range(99) < 19) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.action  <= act;
    req_if.rx_byte <= c;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (act != ACT_UNUSED) requests_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_req(ACT_BYTE, s[i]);
  endtask

  task automatic send_random_bytes(int n);
    for (int i = 0; i < n; i++) send_req(ACT_BYTE, 8'($urandom));
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_body_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic string eol();
    if ($urandom_range(3) == 0) return "\n";
    return "\r\n";
  endfunction

  function automatic string length_line(longint unsigned n);
    string pad;
    string junk;
    case ($urandom_range(3))
      0: pad = "";
      1: pad = " ";
      2: pad = "\t";
      default: pad = " \t ";
    endcase
    case ($urandom_range(4))
      0: junk = " 7";
      1: junk = ";x";
      2: junk = "abc";
      default: junk = "";
    endcase
    if ($urandom_range(4) == 0) pad = {pad, "00"};
    return {"Content-Length:", pad, $sformatf("%0d", n), junk, eol()};
  endfunction

  function automatic string chunk_ext();
    case ($urandom_range(5))
      0: return ";a=1";
      1: return " ;name=val";
      2: return ";ext";
      3: return "\r";
      default: return "";
    endcase
  endfunction

  function automatic string size_text(int n);
    string s;
    s = $sformatf("%0h", n);
    if ($urandom_range(1)) s = s.toupper();
    if ($urandom_range(3) == 0) s = {"0", s};
    return s;
  endfunction

  task automatic send_fillers(int n);
    for (int i = 0; i < n; i++)
      send_text({filler_lines[$urandom_range($size(filler_lines) - 1)], eol()});
  endtask

  task automatic send_plain();
    int n;
    int k;
    n = $urandom_range(0, 12);
    if ($urandom_range(4) == 0) n = 0;
    send_text({"HTTP/1.1 200 OK", eol()});
    if ($urandom_range(2) == 0) send_text(length_line($urandom_range(1, 30)));
    send_fillers($urandom_range(0, 2));
    send_text(length_line(n));
    send_fillers($urandom_range(0, 1));
    send_text(eol());
    if (n > 1 && $urandom_range(5) == 0) begin
      k = $urandom_range(0, n - 1);
      send_random_bytes(k);
      send_req(ACT_CLOSE, 8'($urandom));
    end else begin
      send_random_bytes(n);
      if ($urandom_range(2) == 0) begin
        send_random_bytes($urandom_range(1, 3));
        send_req(ACT_CLOSE, 8'($urandom));
      end
    end
  endtask

  task automatic send_chunked();
    int chunks;
    int size;
    send_text({"HTTP/1.1 200 OK", eol()});
    if ($urandom_range(3) == 0) send_text(length_line($urandom_range(0, 20)));
    send_text({"Transfer-Encoding: chunked", eol()});
    if ($urandom_range(3) == 0) send_text(length_line($urandom_range(0, 20)));
    send_fillers($urandom_range(0, 2));
    send_text(eol());
    chunks = $urandom_range(1, 3);
    for (int i = 0; i < chunks; i++) begin
      size = ($urandom_range(3) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 9);
      send_text({size_text(size), chunk_ext(), eol()});
      if ($urandom_range(11) == 0) begin
        send_random_bytes($urandom_range(0, size - 1));
        send_req(ACT_CLOSE, 8'($urandom));
        return;
      end
      send_random_bytes(size);
      if ($urandom_range(4) == 0) send_text({"zz", eol()});
      else send_text(eol());
    end
    case ($urandom_range(2))
      0: send_text({"0", chunk_ext(), eol()});
      1: send_text(eol());
      default: send_text({"000", eol()});
    endcase
    if ($urandom_range(1)) send_text({"Trailer: x", eol(), eol()});
    if ($urandom_range(2) == 0) send_req(ACT_CLOSE, 8'($urandom));
  endtask

  task automatic send_close_delimited();
    send_text({"HTTP/1.0 200 OK", eol()});
    send_fillers($urandom_range(0, 3));
    send_text(eol());
    send_random_bytes($urandom_range(0, 15));
    send_req(ACT_CLOSE, 8'($urandom));
    if ($urandom_range(3) == 0) send_req(ACT_CLOSE, 8'($urandom));
  endtask

  task automatic send_overflow();
    case ($urandom_range(2))
      0: send_text({"Content-Length: 99999999999999999999", eol(), eol()});
      1: begin
        if ($urandom_range(1)) send_text({"Content-Length: 4294967296", eol(), eol()});
        else send_text({"Content-Length: 4294967295", eol(), eol()});
      end
      default: begin
        send_text({"Transfer-Encoding: chunked", eol(), eol()});
        if ($urandom_range(1)) send_text({"FFFFFFFFFFFF", eol()});
        else send_text({"100000000", eol()});
      end
    endcase
    send_random_bytes($urandom_range(1, 8));
    send_req(ACT_CLOSE, 8'($urandom));
  endtask

  task automatic send_broken();
    int lines;
    if ($urandom_range(1)) begin
      lines = $urandom_range(1, 4);
      for (int i = 0; i < lines; i++) begin
        if ($urandom_range(1)) send_text(filler_lines[$urandom_range($size(filler_lines) - 1)]);
        else send_text("Content-Len\rgth: 12");
        send_text(eol());
      end
      send_req(ACT_CLOSE, 8'($urandom));
    end else begin
      send_text({"Transfer-Encoding: chunked", eol(), eol()});
      if ($urandom_range(1)) send_text({"g", size_text($urandom_range(1, 30)), eol()});
      else send_text({"zz", eol()});
      if ($urandom_range(1)) send_random_bytes($urandom_range(1, 4));
    end
  endtask

  task automatic send_noise();
    int n;
    int r;
    logic [7:0] c;
    n = $urandom_range(10, 30);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      c = 8'($urandom);
      if ($urandom_range(3) == 0) c = CHAR_LF;
      else if ($urandom_range(9) == 0) c = CHAR_CR;
      if (r < 80) send_req(ACT_BYTE, c);
      else if (r < 90) send_req(ACT_UNUSED, c);
      else send_req(ACT_CLOSE, c);
    end
    send_req(ACT_CLOSE, 8'($urandom));
  endtask

  task automatic run_response();
    int kind;
    kind = $urandom_range(99);
    send_req(ACT_START, 8'($urandom));
    if (kind < 30) begin
      send_plain();
      n_plain++;
    end else if (kind < 55) begin
      send_chunked();
      n_chunked++;
    end else if (kind < 68) begin
      send_close_delimited();
      n_close++;
    end else if (kind < 78) begin
      send_broken();
      n_broken++;
    end else if (kind < 86) begin
      send_overflow();
      n_overflow++;
    end else begin
      send_noise();
      n_noise++;
    end
  endtask

  initial begin
    sb             = new();
    rst_ni         = 1'b0;
    steady         = 1'b0;
    quiet_cycles   = 0;
    requests_sent  = 0;
    resp_count     = 0;
    req_if.valid   = 1'b0;
    req_if.action  = ACT_BYTE;
    req_if.rx_byte = 8'h00;
    rsp_if.ready   = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: unused action, empty header, body to close, requests after the end,
    // close during the header, zero length
    send_req(ACT_UNUSED, 8'hFF);
    send_req(ACT_BYTE, CHAR_LF);
    send_req(ACT_BYTE, CHAR_LF);
    send_req(ACT_BYTE, 8'h00);
    send_req(ACT_BYTE, 8'hFF);
    send_req(ACT_CLOSE, 8'h00);
    send_req(ACT_CLOSE, 8'hFF);
    send_req(ACT_BYTE, 8'h41);
    send_req(ACT_START, 8'h00);
    send_req(ACT_BYTE, "C");
    send_req(ACT_CLOSE, 8'h00);
    send_req(ACT_START, 8'hFF);
    send_text("Content-Length:0\n\n");
    drain();

    while (requests_sent < ITEM_GOAL) begin
      steady = (requests_sent >= 200 && requests_sent < 350);
      run_response();
      resp_count++;
      if (resp_count % 25 == 12) drain();
    end
    steady = 1'b0;
    drain();
    repeat (DRAIN_WAIT) @(negedge clk_i);
    while (sb.pending_body_q.size() != 0) begin
      sb.report("expected result never arrived");
      void'(sb.pending_body_q.pop_front());
    end

    $display("summary: %0d requests, %0d results checked over %0d responses",
             requests_sent, sb.checked, resp_count);
    $display("summary: plain %0d, chunked %0d, to close %0d, malformed %0d, overflow %0d, noise %0d",
             n_plain, n_chunked, n_close, n_broken, n_overflow, n_noise);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/hrbd_pkg.sv
rtl/hrbd_if.sv
rtl/hrbd_in_reg.sv
rtl/hrbd_step.sv
rtl/http_response_body_deframer_unit.sv
verif/tb.sv
